FILE: sv/adq_pkg.sv
// Shared constants and types for the A/V drift quality monitor.
`timescale 1ns / 1ps

package adq_pkg;

    // Q8 fixed point full scale, 100 percent
    localparam int unsigned QW = 15;
    localparam logic [QW-1:0] Q8_FULL = 15'd25600;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_QUALITY    = 8'd1;
    localparam logic [31:0] ERROR_THRESHOLD_RST = 32'd40000;
    localparam logic [31:0] ZERO_QUALITY_RST    = 32'd40000;

    // Divider geometry: full 64-bit dividend or short 47-bit dividend
    localparam int unsigned DVD_W       = 64;
    localparam int unsigned DSR_W       = 32;
    localparam int unsigned SHORT_W     = 47;
    localparam int unsigned STEP_CNT_W  = 7;
    localparam logic [STEP_CNT_W-1:0] FULL_STEPS  = 7'd64;
    localparam logic [STEP_CNT_W-1:0] SHORT_STEPS = 7'd47;

    // Divider request from the sequencer
    typedef struct packed {
        logic start;
        logic short_op;
    } div_req_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: sv/adq_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module adq_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  adq_pkg::div_req_t             req,
    input  logic [adq_pkg::DVD_W-1:0]     dividend,
    input  logic [adq_pkg::DSR_W-1:0]     divisor,
    output adq_pkg::div_sts_t             sts,
    output logic [adq_pkg::DVD_W-1:0]     quotient
);

    logic [adq_pkg::DVD_W-1:0]      dvd_reg;
    logic [adq_pkg::DSR_W-1:0]      dsr_reg;
    logic [adq_pkg::DSR_W-1:0]      rem_reg;
    logic [adq_pkg::DSR_W-1:0]      rem_next;
    logic [adq_pkg::DVD_W-1:0]      quo_reg;
    logic [adq_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [adq_pkg::DSR_W:0]        rem_shift;
    logic [adq_pkg::DSR_W:0]        rem_diff;
    logic                           rem_ge;
    logic [adq_pkg::DVD_W-1:0]      dvd_aligned;

    // Short dividends are left-aligned so the same MSB-first walk applies
    assign dvd_aligned = req.short_op
        ? {dividend[adq_pkg::SHORT_W-1:0], {(adq_pkg::DVD_W-adq_pkg::SHORT_W){1'b0}}}
        : dividend;

    // Trial subtract of the shifted partial remainder
    assign rem_shift = {rem_reg, dvd_reg[adq_pkg::DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign rem_ge    = (rem_shift >= {1'b0, dsr_reg});
    assign rem_next  = rem_ge ? rem_diff[adq_pkg::DSR_W-1:0] : rem_shift[adq_pkg::DSR_W-1:0];

    // Step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= req.short_op ? adq_pkg::SHORT_STEPS : adq_pkg::FULL_STEPS;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dvd_aligned;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[adq_pkg::DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[adq_pkg::DVD_W-2:0], rem_ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/av_drift_quality_monitor.sv
// Top level of the A/V drift quality monitor: sequencer, statistics and channels.
`timescale 1ns / 1ps

// Usage
//   s_tvalid/s_tready/s_tdata carry one sync point per transaction (video and
//   audio time in microseconds). m_tvalid/m_tready/m_tdata return one
//   statistics record per sync point, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the error threshold (index 0)
//   and the zero-quality drift (index 1); cfg_ready is always high. Write only
//   while no sync point is in flight.
// Sequencing
//   From the accepting edge to the edge that raises m_tvalid, the shared divider runs
//   a 64-step pass for the mean drift and two 47-step passes for the quality
//   loss and the running average, one bit per cycle, plus the sequencing
//   states between them. The quality-loss pass is skipped when the mean
//   reaches the zero-quality drift. s_tready is high only while idle, so a new
//   sync point is taken only once the last one has left the sequencer.
// Reset
//   rst_n clears all statistics, sets both quality values to 100 percent and
//   loads the register reset values (40000 us each).
// Stall
//   The result sits in an output register; a new sync point may be accepted
//   while it waits. A finished record waits for that register to free up.

module av_drift_quality_monitor
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata fields, low to high: video_time_us[31:0], audio_time_us[31:0]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,
    // m_tdata fields, low to high: current_quality[14:0], average_quality[14:0],
    // peak_drift_us[31:0], error_total[31:0], point_total[31:0], 2 zero bits
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [adq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_UPD       = 4'd1;
    localparam logic [3:0] ST_MEAN_GO   = 4'd2;
    localparam logic [3:0] ST_MEAN_WAIT = 4'd3;
    localparam logic [3:0] ST_QCHK      = 4'd4;
    localparam logic [3:0] ST_LOSS_GO   = 4'd5;
    localparam logic [3:0] ST_LOSS_WAIT = 4'd6;
    localparam logic [3:0] ST_ACC_MUL   = 4'd7;
    localparam logic [3:0] ST_ACC_GO    = 4'd8;
    localparam logic [3:0] ST_ACC_WAIT  = 4'd9;
    localparam logic [3:0] ST_OUT       = 4'd10;

    localparam int unsigned PROD_W = adq_pkg::DSR_W + adq_pkg::QW;

    logic [3:0]   state_reg;
    logic [3:0]   state_next;

    logic [31:0]  err_thr_reg;
    logic [31:0]  zero_q_reg;

    logic [31:0]  drift_reg;
    logic [63:0]  drift_sum_reg;
    logic [31:0]  drift_peak_reg;
    logic [31:0]  error_count_reg;
    logic [31:0]  sample_count_reg;
    logic [adq_pkg::QW-1:0] quality_now_reg;
    logic [adq_pkg::QW-1:0] quality_mean_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] mul_out;
    logic [31:0]       mul_a;
    logic [adq_pkg::QW-1:0] mul_b;
    logic [PROD_W-1:0] acc_sum;

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    logic         s_accept;
    logic         out_free;
    logic [31:0]  vid_t;
    logic [31:0]  aud_t;
    logic [31:0]  drift_in;
    logic [64:0]  sum_add;
    logic [31:0]  z_eff;
    logic         mean_ge_z;

    adq_pkg::div_req_t div_req;
    adq_pkg::div_sts_t div_sts;
    logic [adq_pkg::DVD_W-1:0] div_dividend;
    logic [adq_pkg::DSR_W-1:0] div_divisor;
    logic [adq_pkg::DVD_W-1:0] div_quot;

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Absolute drift of the incoming sync point
    assign vid_t    = s_tdata[31:0];
    assign aud_t    = s_tdata[63:32];
    assign drift_in = (vid_t >= aud_t) ? (vid_t - aud_t) : (aud_t - vid_t);

    assign sum_add   = {1'b0, drift_sum_reg} + {33'd0, drift_reg};
    assign z_eff     = (zero_q_reg == 32'd0) ? 32'd1 : zero_q_reg;
    assign mean_ge_z = (div_quot >= {32'd0, z_eff});

    // Shared multiplier: mean * full scale, or old average * (count - 1)
    assign mul_a   = (state_reg == ST_QCHK) ? div_quot[31:0] : (sample_count_reg - 32'd1);
    assign mul_b   = (state_reg == ST_QCHK) ? adq_pkg::Q8_FULL : quality_mean_reg;
    assign mul_out = mul_a * mul_b;
    assign acc_sum = prod_reg + {{(PROD_W-adq_pkg::QW){1'b0}}, quality_now_reg};

    // Divider operand selection
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.short_op = 1'b0;
        div_dividend     = drift_sum_reg;
        div_divisor      = sample_count_reg;
        case (state_reg)
            ST_MEAN_GO:
            begin
                div_req.start = 1'b1;
            end
            ST_LOSS_GO:
            begin
                div_req.start    = 1'b1;
                div_req.short_op = 1'b1;
                div_dividend     = {{(adq_pkg::DVD_W-PROD_W){1'b0}}, prod_reg};
                div_divisor      = z_eff;
            end
            ST_ACC_GO:
            begin
                div_req.start    = 1'b1;
                div_req.short_op = 1'b1;
                div_dividend     = {{(adq_pkg::DVD_W-PROD_W){1'b0}}, acc_sum};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    adq_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quot)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_accept) state_next = ST_UPD;
            ST_UPD:       state_next = ST_MEAN_GO;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (div_sts.done) state_next = ST_QCHK;
            ST_QCHK:      state_next = mean_ge_z ? ST_ACC_MUL : ST_LOSS_GO;
            ST_LOSS_GO:   state_next = ST_LOSS_WAIT;
            ST_LOSS_WAIT: if (div_sts.done) state_next = ST_ACC_MUL;
            ST_ACC_MUL:   state_next = ST_ACC_GO;
            ST_ACC_GO:    state_next = ST_ACC_WAIT;
            ST_ACC_WAIT:  if (div_sts.done) state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            err_thr_reg      <= adq_pkg::ERROR_THRESHOLD_RST;
            zero_q_reg       <= adq_pkg::ZERO_QUALITY_RST;
            drift_sum_reg    <= '0;
            drift_peak_reg   <= '0;
            error_count_reg  <= '0;
            sample_count_reg <= '0;
            quality_now_reg  <= adq_pkg::Q8_FULL;
            quality_mean_reg <= adq_pkg::Q8_FULL;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    adq_pkg::CFG_ERROR_THRESHOLD: err_thr_reg <= cfg_data;
                    adq_pkg::CFG_ZERO_QUALITY:    zero_q_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Running statistics, one update per sync point
            if (state_reg == ST_UPD)
            begin
                drift_sum_reg <= sum_add[64] ? {64{1'b1}} : sum_add[63:0];
                if (drift_reg > drift_peak_reg)
                    drift_peak_reg <= drift_reg;
                if (drift_reg > err_thr_reg && error_count_reg != 32'hFFFF_FFFF)
                    error_count_reg <= error_count_reg + 32'd1;
                if (sample_count_reg != 32'hFFFF_FFFF)
                    sample_count_reg <= sample_count_reg + 32'd1;
            end

            // Current quality
            if (state_reg == ST_QCHK && mean_ge_z)
                quality_now_reg <= '0;
            if (state_reg == ST_LOSS_WAIT && div_sts.done)
                quality_now_reg <= adq_pkg::Q8_FULL - div_quot[adq_pkg::QW-1:0];

            // Average quality
            if (state_reg == ST_ACC_WAIT && div_sts.done)
                quality_mean_reg <= div_quot[adq_pkg::QW-1:0];

            // Output valid
            if (state_reg == ST_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
            drift_reg <= drift_in;
        if (state_reg == ST_QCHK || state_reg == ST_ACC_MUL)
            prod_reg <= mul_out;
        if (state_reg == ST_OUT && out_free)
            m_tdata_reg <= {2'b00, sample_count_reg, error_count_reg, drift_peak_reg,
                            quality_mean_reg, quality_now_reg};
    end

`ifndef ASSERT_OFF
    // An accepted sync point always starts the statistics update
    a_accept_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_UPD))
        else $error("accepted sync point did not enter update");

    // The divider is never restarted while a pass is running
    a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    // A new result only appears out of the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result valid raised outside output state");

    // Quality values stay within full scale
    a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
        (quality_now_reg <= adq_pkg::Q8_FULL) && (quality_mean_reg <= adq_pkg::Q8_FULL))
        else $error("quality above full scale");
`endif

endmodule
